### hdl/qdsf_pkg.sv
package qdsf_pkg;

    // Item classes as the front end sorts them.
    typedef enum logic {
        CMD_SAMPLE = 1'b0,
        CMD_PERIOD = 1'b1
    } t_cmd;

    // Step direction of one pin sample, also shown on the result.
    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_UP   = 2'd1,
        DIR_DOWN = 2'd2
    } t_dir;

    // One classified operation as it sits in the queue.
    typedef struct packed {
        t_cmd cmd;
        t_dir dir;
    } t_op;

    // Write side of the queue, driven by the front end.
    typedef struct packed {
        logic push;
        t_op  op;
    } t_q_wr;

    // Read side of the queue, seen by the back end.
    typedef struct packed {
        logic valid;
        t_op  op;
    } t_q_rd;

    // Configuration register file.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_SCALE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_COEF = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_SCALE = 2'd2;

    localparam logic [31:0] SPEED_SCALE_RST = 32'd65536;
    localparam logic [16:0] FILTER_COEF_RST = 17'd6554;
    localparam logic [31:0] ANGLE_SCALE_RST = 32'd3755;

    // Unity in Q1.16, the largest filter weight that has a meaning.
    localparam logic [16:0] COEF_UNITY = 17'd65536;

    typedef struct packed {
        logic [31:0] speed_scale;
        logic [16:0] filter_coef;
        logic [31:0] angle_scale;
    } t_cfg;

    // Queue between front and back end.
    localparam int Q_DEPTH = 2;

    // Back end sequencer.
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_RAW_MUL,
        BK_RAW_SAT,
        BK_FILT_MUL,
        BK_FILT_SUM,
        BK_ANG_MUL,
        BK_ANG_ADD
    } t_back_state;

    // x4 Gray decode of the transition from prev to cur phase ({A, B}).
    function automatic t_dir step_decode(input logic [1:0] prev, input logic [1:0] cur);
        t_dir dir;
        case ({prev, cur})
            4'b10_00, 4'b00_01, 4'b11_10, 4'b01_11: dir = DIR_UP;
            4'b01_00, 4'b11_01, 4'b00_10, 4'b10_11: dir = DIR_DOWN;
            default:                                dir = DIR_NONE;
        endcase
        return dir;
    endfunction

endpackage

### hdl/qdsf_in_if.sv
interface qdsf_in_if;
    logic valid;
    logic ready;
    logic cmd;
    logic pin_a;
    logic pin_b;

    modport source (output valid, output cmd, output pin_a, output pin_b, input ready);
    modport sink   (input valid, input cmd, input pin_a, input pin_b, output ready);
endinterface

### hdl/qdsf_out_if.sv
interface qdsf_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] position;
    logic signed [31:0] raw_speed;
    logic signed [31:0] smooth_speed;
    logic signed [47:0] angle;
    logic        [1:0]  step_dir;

    modport source (
        output valid, output position, output raw_speed, output smooth_speed,
        output angle, output step_dir, input ready
    );
    modport sink (
        input valid, input position, input raw_speed, input smooth_speed,
        input angle, input step_dir, output ready
    );
endinterface

### hdl/qdsf_front.sv
module qdsf_front
    import qdsf_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    qdsf_in_if.sink       i_in,
    input  logic          i_q_full,
    output t_q_wr         o_q_wr
);

    logic [1:0] r_prev_phase;
    logic [1:0] n_prev_phase;
    logic [1:0] cur_phase;
    logic       accept;
    t_cmd       cmd;

    assign cur_phase  = {i_in.pin_a, i_in.pin_b};
    assign cmd        = t_cmd'(i_in.cmd);
    assign i_in.ready = !i_q_full;
    assign accept     = i_in.valid && !i_q_full;

    always_comb begin
        n_prev_phase   = r_prev_phase;
        o_q_wr.push    = accept;
        o_q_wr.op.cmd  = cmd;
        o_q_wr.op.dir  = DIR_NONE;
        if (cmd == CMD_SAMPLE) begin
            o_q_wr.op.dir = step_decode(r_prev_phase, cur_phase);
            if (accept) begin
                n_prev_phase = cur_phase;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_phase <= 2'd0;
        end else begin
            r_prev_phase <= n_prev_phase;
        end
    end

endmodule

### hdl/qdsf_queue.sv
module qdsf_queue
    import qdsf_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_q_wr i_wr,
    output logic  o_full,
    input  logic  i_pop,
    output t_q_rd o_rd
);

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(Q_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(Q_DEPTH);

    t_op              r_mem [Q_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full     = (r_count == CNT_FULL);
    assign o_rd.valid = (r_count != '0);
    assign o_rd.op    = r_mem[r_rd_ptr];
    assign do_push    = i_wr.push && !o_full;
    assign do_pop     = i_pop && o_rd.valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_wr.op;
        end
    end

endmodule

### hdl/qdsf_back.sv
module qdsf_back
    import qdsf_pkg::*;
#(
    parameter int COUNT_BITS = 32,
    parameter int ANGLE_BITS = 48
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  t_q_rd     i_rd,
    output logic      o_pop,
    qdsf_out_if.source o_out
);

    localparam logic signed [COUNT_BITS-1:0] D_MAX = COUNT_BITS'(32767);
    localparam logic signed [COUNT_BITS-1:0] D_MIN = COUNT_BITS'(-32768);
    localparam logic signed [65:0] S32_MAX  = 66'sd2147483647;
    localparam logic signed [65:0] S32_MIN  = -66'sd2147483648;
    localparam logic signed [65:0] RND_HALF = 66'sd32768;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] res;
        if (v > S32_MAX) begin
            res = 32'sh7FFF_FFFF;
        end else if (v < S32_MIN) begin
            res = 32'sh8000_0000;
        end else begin
            res = 32'(v);
        end
        return res;
    endfunction

    t_back_state               r_state, n_state;
    logic [COUNT_BITS-1:0]     r_step_count, n_step_count;
    logic [COUNT_BITS-1:0]     r_count_at_period, n_count_at_period;
    logic signed [31:0]        r_raw, n_raw;
    logic signed [31:0]        r_filt, n_filt;
    logic [ANGLE_BITS-1:0]     r_angle, n_angle;
    logic signed [15:0]        r_d, n_d;
    logic signed [65:0]        r_prod, n_prod;

    logic                      r_out_valid, n_out_valid;
    logic signed [31:0]        r_o_position, n_o_position;
    logic signed [31:0]        r_o_raw, n_o_raw;
    logic signed [31:0]        r_o_smooth, n_o_smooth;
    logic signed [47:0]        r_o_angle, n_o_angle;
    t_dir                      r_o_dir, n_o_dir;

    logic                      out_free;
    logic signed [COUNT_BITS-1:0] cnt_diff;
    logic [16:0]               coef_a;
    logic signed [32:0]        mul_a, mul_b;
    logic signed [65:0]        mul_p;
    logic signed [65:0]        filt_sum;
    logic signed [65:0]        ang_inc;
    logic [ANGLE_BITS-1:0]     angle_next;
    logic signed [COUNT_BITS-1:0] pos_s;
    logic signed [ANGLE_BITS-1:0] ang_s;

    assign out_free   = !r_out_valid || o_out.ready;
    assign cnt_diff   = $signed(r_step_count - r_count_at_period);
    assign coef_a     = (i_cfg.filter_coef > COEF_UNITY) ? COEF_UNITY : i_cfg.filter_coef;
    assign mul_p      = mul_a * mul_b;
    assign filt_sum   = r_prod + (66'(r_filt) <<< 16) + RND_HALF;
    assign ang_inc    = (r_prod + RND_HALF) >>> 16;
    assign angle_next = r_angle + ANGLE_BITS'(ang_inc);

    always_comb begin
        n_state           = r_state;
        n_step_count      = r_step_count;
        n_count_at_period = r_count_at_period;
        n_raw             = r_raw;
        n_filt            = r_filt;
        n_angle           = r_angle;
        n_d               = r_d;
        n_prod            = r_prod;
        n_out_valid       = r_out_valid && !o_out.ready;
        n_o_position      = r_o_position;
        n_o_raw           = r_o_raw;
        n_o_smooth        = r_o_smooth;
        n_o_angle         = r_o_angle;
        n_o_dir           = r_o_dir;
        o_pop             = 1'b0;
        mul_a             = '0;
        mul_b             = '0;
        pos_s             = $signed(r_step_count);
        ang_s             = $signed(r_angle);

        case (r_state)
            BK_IDLE: begin
                if (i_rd.valid) begin
                    if (i_rd.op.cmd == CMD_SAMPLE) begin
                        if (out_free) begin
                            o_pop = 1'b1;
                            case (i_rd.op.dir)
                                DIR_UP:   n_step_count = r_step_count + 1'b1;
                                DIR_DOWN: n_step_count = r_step_count - 1'b1;
                                default:  n_step_count = r_step_count;
                            endcase
                            pos_s        = $signed(n_step_count);
                            n_out_valid  = 1'b1;
                            n_o_position = 32'(pos_s);
                            n_o_raw      = r_raw;
                            n_o_smooth   = r_filt;
                            n_o_angle    = 48'(ang_s);
                            n_o_dir      = i_rd.op.dir;
                        end
                    end else begin
                        o_pop = 1'b1;
                        if (cnt_diff > D_MAX) begin
                            n_d = 16'sh7FFF;
                        end else if (cnt_diff < D_MIN) begin
                            n_d = 16'sh8000;
                        end else begin
                            n_d = 16'(cnt_diff);
                        end
                        n_count_at_period = r_step_count;
                        n_state           = BK_RAW_MUL;
                    end
                end
            end
            BK_RAW_MUL: begin
                mul_a   = 33'(r_d);
                mul_b   = $signed({1'b0, i_cfg.speed_scale});
                n_prod  = mul_p;
                n_state = BK_RAW_SAT;
            end
            BK_RAW_SAT: begin
                n_raw   = sat32(r_prod);
                n_state = BK_FILT_MUL;
            end
            BK_FILT_MUL: begin
                // a*raw + (1-a)*filt is formed as a*(raw - filt) + filt.
                mul_a   = 33'(r_raw) - 33'(r_filt);
                mul_b   = $signed({16'd0, coef_a});
                n_prod  = mul_p;
                n_state = BK_FILT_SUM;
            end
            BK_FILT_SUM: begin
                n_filt  = sat32(filt_sum >>> 16);
                n_state = BK_ANG_MUL;
            end
            BK_ANG_MUL: begin
                mul_a   = 33'(r_filt);
                mul_b   = $signed({1'b0, i_cfg.angle_scale});
                n_prod  = mul_p;
                n_state = BK_ANG_ADD;
            end
            BK_ANG_ADD: begin
                if (out_free) begin
                    n_angle      = angle_next;
                    ang_s        = $signed(angle_next);
                    n_out_valid  = 1'b1;
                    n_o_position = 32'(pos_s);
                    n_o_raw      = r_raw;
                    n_o_smooth   = r_filt;
                    n_o_angle    = 48'(ang_s);
                    n_o_dir      = DIR_NONE;
                    n_state      = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state           <= BK_IDLE;
            r_step_count      <= '0;
            r_count_at_period <= '0;
            r_raw             <= '0;
            r_filt            <= '0;
            r_angle           <= '0;
            r_out_valid       <= 1'b0;
        end else begin
            r_state           <= n_state;
            r_step_count      <= n_step_count;
            r_count_at_period <= n_count_at_period;
            r_raw             <= n_raw;
            r_filt            <= n_filt;
            r_angle           <= n_angle;
            r_out_valid       <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d          <= n_d;
        r_prod       <= n_prod;
        r_o_position <= n_o_position;
        r_o_raw      <= n_o_raw;
        r_o_smooth   <= n_o_smooth;
        r_o_angle    <= n_o_angle;
        r_o_dir      <= n_o_dir;
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.position     = r_o_position;
    assign o_out.raw_speed    = r_o_raw;
    assign o_out.smooth_speed = r_o_smooth;
    assign o_out.angle        = r_o_angle;
    assign o_out.step_dir     = r_o_dir;

endmodule

### hdl/quadrature_decoder_speed_filter.sv
// One channel of an x4 quadrature encoder decoder with speed estimation. Each
// input transfer is either a pin sample (cmd 0), which steps a wrapping
// COUNT_BITS position count by one up or down on a valid Gray transition, or a
// period tick (cmd 1), which turns the count change since the previous tick
// into a Q16.16 speed, low-pass filters it and integrates the filtered speed
// into a wrapping Q32.16 angle. Every input transfer yields exactly one output
// transfer carrying position, both speeds, angle and the step direction. A pin
// sample is handled in the back end's idle state, while a period tick runs
// through a sequence of states built around the single shared 33 x 33
// multiplier, which is used three times in a row with a registered rounding
// or saturation step after each use. A two-entry queue sits between the
// classifying front end and the back end, and the result sits in an output
// register, so new items keep arriving while a result waits to be taken,
// until the queue is full. Configuration registers are written through a
// plain write port and must only be written while the block is idle.
module quadrature_decoder_speed_filter
    import qdsf_pkg::*;
#(
    parameter int COUNT_BITS = 32,
    parameter int ANGLE_BITS = 48
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    qdsf_in_if.sink               i_in,
    qdsf_out_if.source            o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    // Configuration registers. The filter weight keeps only its low 17 bits;
    // values above unity are clamped where the weight is used.
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.speed_scale <= SPEED_SCALE_RST;
            r_cfg.filter_coef <= FILTER_COEF_RST;
            r_cfg.angle_scale <= ANGLE_SCALE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SPEED_SCALE: r_cfg.speed_scale <= i_cfg_wdata;
                CFG_FILTER_COEF: r_cfg.filter_coef <= i_cfg_wdata[16:0];
                CFG_ANGLE_SCALE: r_cfg.angle_scale <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // The front end owns the previous phase, so the step direction of a sample
    // is settled before it enters the queue.
    t_q_wr q_wr;
    t_q_rd q_rd;
    logic  q_full;
    logic  q_pop;

    qdsf_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_q_wr   (q_wr)
    );

    qdsf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_rd    (q_rd)
    );

    // The back end holds the count, speed, filter and angle state and runs the
    // period arithmetic as a short sequence on one multiplier.
    qdsf_back #(
        .COUNT_BITS (COUNT_BITS),
        .ANGLE_BITS (ANGLE_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_rd    (q_rd),
        .o_pop   (q_pop),
        .o_out   (o_out)
    );

endmodule

### hdl/qdsf_checker.sv
module qdsf_checker
    import qdsf_pkg::*;
#(
    parameter int COUNT_BITS = 32
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic signed [31:0] i_position,
    input logic signed [31:0] i_raw_speed,
    input logic signed [31:0] i_smooth_speed,
    input logic signed [47:0] i_angle,
    input logic        [1:0]  i_step_dir
);

    // Copy of the previous output transfer; state is zero after reset.
    logic [COUNT_BITS-1:0] r_last_pos;
    logic signed [31:0]    r_last_raw;
    logic signed [31:0]    r_last_smooth;
    logic signed [47:0]    r_last_angle;
    logic [COUNT_BITS-1:0] exp_pos;
    logic                  xfer;

    assign xfer = i_out_valid && i_out_ready;

    always_comb begin
        case (t_dir'(i_step_dir))
            DIR_UP:   exp_pos = r_last_pos + 1'b1;
            DIR_DOWN: exp_pos = r_last_pos - 1'b1;
            default:  exp_pos = r_last_pos;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_pos    <= '0;
            r_last_raw    <= '0;
            r_last_smooth <= '0;
            r_last_angle  <= '0;
        end else if (xfer) begin
            r_last_pos    <= i_position[COUNT_BITS-1:0];
            r_last_raw    <= i_raw_speed;
            r_last_smooth <= i_smooth_speed;
            r_last_angle  <= i_angle;
        end
    end

    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_position)
            && $stable(i_angle) && $stable(i_step_dir))
        else $error("stalled result changed");

    a_position_tracks_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        xfer |-> i_position[COUNT_BITS-1:0] == exp_pos)
        else $error("position does not follow the step direction");

    a_step_keeps_speed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        xfer && i_step_dir != DIR_NONE |-> i_raw_speed == r_last_raw
            && i_smooth_speed == r_last_smooth && i_angle == r_last_angle)
        else $error("a step result changed speed or angle");

endmodule

bind quadrature_decoder_speed_filter qdsf_checker #(
    .COUNT_BITS (COUNT_BITS)
) u_qdsf_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_position     (o_out.position),
    .i_raw_speed    (o_out.raw_speed),
    .i_smooth_speed (o_out.smooth_speed),
    .i_angle        (o_out.angle),
    .i_step_dir     (o_out.step_dir)
);
